@@ hw/rtl/idws_pkg.sv @@
// Package with the shared types, codes and step decoder of the display write sequencer.
package idws_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned STEP_W    = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CMD  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_DATA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;

    localparam logic [BYTE_W-1:0] SLAVE_ADDRESS_RESET = 8'h78;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET    = 16'd1;
    localparam logic [BYTE_W-1:0] CTRL_DATA           = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_COMMAND        = 8'h00;

    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    localparam logic [2:0] ACT_SCL_LO = 3'd0;
    localparam logic [2:0] ACT_SCL_HI = 3'd1;
    localparam logic [2:0] ACT_SDA_LO = 3'd2;
    localparam logic [2:0] ACT_SDA_HI = 3'd3;
    localparam logic [2:0] ACT_SDA_BIT = 3'd4;
    localparam logic [2:0] ACT_END    = 3'd5;

    localparam logic [1:0] SEL_ADDRESS = 2'd0;
    localparam logic [1:0] SEL_CONTROL = 2'd1;
    localparam logic [1:0] SEL_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_data;
        logic [BYTE_W-1:0] payload;
    } idws_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic [1:0] byte_sel;
        logic [2:0] bit_sel;
    } step_dec_t;

    function automatic step_dec_t step_decode(input logic [STEP_W-1:0] s);
        step_dec_t         d;
        logic [STEP_W-1:0] t;
        logic [4:0]        r;
        logic [2:0]        k;
        logic [4:0]        ph;
        d = '{act: ACT_END, byte_sel: SEL_ADDRESS, bit_sel: 3'd0};
        t = s - 7'd4;
        k = 3'd0;
        if (t >= 7'd56) begin
            d.byte_sel = SEL_PAYLOAD;
            r = 5'(t - 7'd56);
        end
        else if (t >= 7'd28) begin
            d.byte_sel = SEL_CONTROL;
            r = 5'(t - 7'd28);
        end
        else begin
            d.byte_sel = SEL_ADDRESS;
            r = 5'(t);
        end
        for (int i = 1; i < 8; i++) begin
            if (r >= 5'(3 * i)) begin
                k = k + 3'd1;
            end
        end
        ph = r - {1'b0, k, 1'b0} - {2'b00, k};
        d.bit_sel = k;
        if (s < 7'd4) begin
            case (s[1:0])
                2'd0:    d.act = ACT_SDA_HI;
                2'd1:    d.act = ACT_SCL_HI;
                2'd2:    d.act = ACT_SDA_LO;
                default: d.act = ACT_SCL_LO;
            endcase
        end
        else if (s < 7'd88) begin
            if (r < 5'd24) begin
                if (ph == 5'd0) begin
                    d.act = ACT_SCL_LO;
                end
                else if (ph == 5'd1) begin
                    d.act = ACT_SDA_BIT;
                end
                else begin
                    d.act = ACT_SCL_HI;
                end
            end
            else if (r == 5'd25) begin
                d.act = ACT_SDA_HI;
            end
            else if (r == 5'd26) begin
                d.act = ACT_SCL_HI;
            end
            else begin
                d.act = ACT_SCL_LO;
            end
        end
        else if (s == 7'd88) begin
            d.act = ACT_SDA_LO;
        end
        else if (s == 7'd89) begin
            d.act = ACT_SCL_HI;
        end
        else begin
            d.act = ACT_END;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/idws_intf.sv @@
// Interfaces for the request, result and configuration channels.
interface idws_req_if;
    import idws_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] payload_byte;
    modport source (output valid, operation, payload_byte, input ready);
    modport sink (input valid, operation, payload_byte, output ready);
endinterface

interface idws_rsp_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic accepted;
    logic transfer_done;
    modport source (output valid, scl_level, sda_level, busy_res, accepted, transfer_done,
                    input ready);
    modport sink (input valid, scl_level, sda_level, busy_res, accepted, transfer_done,
                  output ready);
endinterface

interface idws_cfg_if;
    import idws_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/i2c_display_write_sequencer_top.sv @@
// Top level of the write-only I2C display sequencer.
// Each request word yields exactly one result word. A load word that arrives while no transfer runs
// starts a transfer of start, slave address, control byte, payload byte and stop (91 line steps), and
// tick words advance it by one line step every hold_ticks ticks (a zero setting counts as one). The
// block sustains one word per clock cycle in both directions while result words are taken; an
// accepted request is written into the queue, and the back end moves it from the queue into the
// result register, its step update setting that rate. Configuration writes are taken in any cycle
// and should be made while no transfer runs.
module i2c_display_write_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    idws_req_if.sink   req,
    idws_rsp_if.source rsp,
    idws_cfg_if.sink   cfg
);
    import idws_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      not_empty;
    idws_cmd_t push_cmd;
    idws_cmd_t head_cmd;

    idws_front u_front (
        .req        (req),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    idws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    idws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .cfg       (cfg),
        .rsp       (rsp)
    );
endmodule

@@ hw/rtl/idws_front.sv @@
// Front end that accepts request words and classifies them into queue entries.
module idws_front (
    idws_req_if.sink               req,
    output logic                   push,
    output idws_pkg::idws_cmd_t    push_cmd,
    input  logic                   queue_full
);
    import idws_pkg::*;

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;

    always_comb
    begin
        push_cmd.payload = req.payload_byte;
        push_cmd.is_data = (req.operation == OP_LOAD_DATA);
        unique case (req.operation) inside
            OP_TICK:                   push_cmd.kind = KIND_TICK;
            OP_LOAD_CMD, OP_LOAD_DATA: push_cmd.kind = KIND_LOAD;
            default:                   push_cmd.kind = KIND_NOP;
        endcase
    end
endmodule

@@ hw/rtl/idws_queue.sv @@
// Short first-in first-out queue between the front and back ends.
module idws_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  idws_pkg::idws_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output idws_pkg::idws_cmd_t head_cmd
);
    import idws_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    idws_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

@@ hw/rtl/idws_back.sv @@
// Back end that runs the line sequence, holds the registers and drives the result word.
module idws_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  idws_pkg::idws_cmd_t head_cmd,
    output logic                pop,
    idws_cfg_if.sink            cfg,
    idws_rsp_if.source          rsp
);
    import idws_pkg::*;

    logic [BYTE_W-1:0] slave_addr_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [BYTE_W-1:0] payload_reg;
    logic [BYTE_W-1:0] payload_next;
    logic              is_data_reg;
    logic              is_data_next;
    logic              scl_reg;
    logic              scl_next;
    logic              sda_reg;
    logic              sda_next;
    logic              active_reg;
    logic              active_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic              valid_reg;
    logic              valid_next;
    logic              acc_reg;
    logic              acc_next;
    logic              done_reg;
    logic              done_next;

    step_dec_t         dec;
    logic [BYTE_W-1:0] cur_byte;
    logic [HOLD_W-1:0] limit;
    logic [HOLD_W:0]   hold_inc;

    assign cfg.ready         = 1'b1;
    assign pop               = not_empty && (!valid_reg || rsp.ready);
    assign rsp.valid         = valid_reg;
    assign rsp.scl_level     = scl_reg;
    assign rsp.sda_level     = sda_reg;
    assign rsp.busy_res      = active_reg;
    assign rsp.accepted      = acc_reg;
    assign rsp.transfer_done = done_reg;

    assign dec      = step_decode(step_reg);
    assign limit    = (hold_ticks_reg == '0) ? HOLD_W'(1) : hold_ticks_reg;
    assign hold_inc = {1'b0, hold_reg} + (HOLD_W + 1)'(1);

    always_comb
    begin
        unique case (dec.byte_sel)
            SEL_ADDRESS: cur_byte = slave_addr_reg;
            SEL_CONTROL: cur_byte = is_data_reg ? CTRL_DATA : CTRL_COMMAND;
            default:     cur_byte = payload_reg;
        endcase
    end

    always_comb
    begin
        step_next    = step_reg;
        payload_next = payload_reg;
        is_data_next = is_data_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        active_next  = active_reg;
        hold_next    = hold_reg;
        valid_next   = valid_reg;
        acc_next     = acc_reg;
        done_next    = done_reg;
        if (rsp.ready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            valid_next = 1'b1;
            acc_next   = 1'b0;
            done_next  = 1'b0;
            if (head_cmd.kind == KIND_LOAD && !active_reg) begin
                payload_next = head_cmd.payload;
                is_data_next = head_cmd.is_data;
                step_next    = '0;
                hold_next    = '0;
                active_next  = 1'b1;
                acc_next     = 1'b1;
            end
            else if (head_cmd.kind == KIND_TICK && active_reg) begin
                if (hold_inc >= {1'b0, limit}) begin
                    hold_next = '0;
                    step_next = step_reg + STEP_W'(1);
                    unique case (dec.act)
                        ACT_SCL_LO:  scl_next = 1'b0;
                        ACT_SCL_HI:  scl_next = 1'b1;
                        ACT_SDA_LO:  sda_next = 1'b0;
                        ACT_SDA_HI:  sda_next = 1'b1;
                        ACT_SDA_BIT: sda_next = cur_byte[3'd7 - dec.bit_sel];
                        default:
                        begin
                            sda_next    = 1'b1;
                            done_next   = 1'b1;
                            active_next = 1'b0;
                            step_next   = '0;
                        end
                    endcase
                end
                else begin
                    hold_next = hold_inc[HOLD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_addr_reg <= SLAVE_ADDRESS_RESET;
            hold_ticks_reg <= HOLD_TICKS_RESET;
        end
        else if (cfg.valid) begin
            if (cfg.index == REG_SLAVE_ADDRESS) begin
                slave_addr_reg <= cfg.data[BYTE_W-1:0];
            end
            else if (cfg.index == REG_HOLD_TICKS) begin
                hold_ticks_reg <= cfg.data[HOLD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg    <= '0;
            payload_reg <= '0;
            is_data_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            active_reg  <= 1'b0;
            hold_reg    <= '0;
            valid_reg   <= 1'b0;
            acc_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else begin
            step_reg    <= step_next;
            payload_reg <= payload_next;
            is_data_reg <= is_data_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            active_reg  <= active_next;
            hold_reg    <= hold_next;
            valid_reg   <= valid_next;
            acc_reg     <= acc_next;
            done_reg    <= done_next;
        end
    end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the display write sequencer: directed and random words against a predictor.
module tb_top;
    import idws_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED   = 2'd3;
    localparam int unsigned     RANDOM_WORDS  = 550;
    localparam int unsigned     DRAIN_CYCLES  = 6;
    localparam int unsigned     CYCLE_LIMIT   = 1000000;
    localparam int unsigned     MAX_REPORTS   = 10;
    localparam int unsigned     HOLDOFF_LONG  = 400;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic accepted;
        logic transfer_done;
    } line_word_t;

    logic clk;
    logic rst_n;

    idws_req_if req_ch ();
    idws_rsp_if rsp_ch ();
    idws_cfg_if cfg_ch ();

    i2c_display_write_sequencer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted bus state and register copies.
    logic [STEP_W-1:0] bus_step          = '0;
    logic [BYTE_W-1:0] bus_payload       = '0;
    logic              bus_is_data       = 1'b0;
    logic              bus_scl           = 1'b1;
    logic              bus_sda           = 1'b1;
    logic              bus_active        = 1'b0;
    logic [HOLD_W-1:0] bus_hold_count    = '0;
    logic [BYTE_W-1:0] reg_slave_address = SLAVE_ADDRESS_RESET;
    logic [HOLD_W-1:0] reg_hold_ticks    = HOLD_TICKS_RESET;

    line_word_t  pending_lines[$];
    int unsigned mismatch_count  = 0;
    int unsigned words_checked   = 0;
    int unsigned transfers_seen  = 0;
    int unsigned loads_refused   = 0;
    int unsigned traffic_words   = 0;
    int unsigned cycle_count     = 0;

    rx_mode_e    rx_mode         = RX_ALWAYS;
    int unsigned holdoff_request = 0;
    int unsigned holdoff_left    = 0;
    bit          gaps_on         = 1'b0;
    int unsigned burst_left      = 0;

    function automatic logic advance_lines();
        int         s;
        int         b;
        int         r;
        int         k;
        logic [7:0] v;
        s = int'(bus_step);
        if (s < 4) begin
            case (s)
                0:       bus_sda = 1'b1;
                1:       bus_scl = 1'b1;
                2:       bus_sda = 1'b0;
                default: bus_scl = 1'b0;
            endcase
        end
        else if (s < 88) begin
            b = (s - 4) / 28;
            r = (s - 4) % 28;
            if (b == 0) begin
                v = reg_slave_address;
            end
            else if (b == 1) begin
                v = bus_is_data ? CTRL_DATA : CTRL_COMMAND;
            end
            else begin
                v = bus_payload;
            end
            if (r < 24) begin
                k = r / 3;
                case (r % 3)
                    0:       bus_scl = 1'b0;
                    1:       bus_sda = v[7 - k];
                    default: bus_scl = 1'b1;
                endcase
            end
            else if (r == 25) begin
                bus_sda = 1'b1;
            end
            else if (r == 26) begin
                bus_scl = 1'b1;
            end
            else begin
                bus_scl = 1'b0;
            end
        end
        else if (s == 88) begin
            bus_sda = 1'b0;
        end
        else if (s == 89) begin
            bus_scl = 1'b1;
        end
        else begin
            bus_sda = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic line_word_t predict_line_word(input logic [OP_W-1:0] op,
                                                     input logic [BYTE_W-1:0] pay);
        line_word_t w;
        int         lim;
        int         n;
        w.accepted      = 1'b0;
        w.transfer_done = 1'b0;
        if (op == OP_LOAD_CMD || op == OP_LOAD_DATA) begin
            if (!bus_active) begin
                bus_payload    = pay;
                bus_is_data    = (op == OP_LOAD_DATA);
                bus_step       = '0;
                bus_hold_count = '0;
                bus_active     = 1'b1;
                w.accepted     = 1'b1;
            end
            else begin
                loads_refused++;
            end
        end
        else if (op == OP_TICK && bus_active) begin
            lim = (reg_hold_ticks == '0) ? 1 : int'(reg_hold_ticks);
            n   = int'(bus_hold_count) + 1;
            if (n >= lim) begin
                bus_hold_count = '0;
                if (advance_lines()) begin
                    w.transfer_done = 1'b1;
                    bus_active      = 1'b0;
                    bus_step        = '0;
                end
                else begin
                    bus_step = bus_step + STEP_W'(1);
                end
            end
            else begin
                bus_hold_count = HOLD_W'(n);
            end
        end
        w.scl_level = bus_scl;
        w.sda_level = bus_sda;
        w.busy_res  = bus_active;
        return w;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, pending_lines.size());
            $display("** i2c_display_write_sequencer_top: FAILED **");
            $finish;
        end
    end

    // Register writes, result checks and predictions all happen on the sampling edge.
    always @(posedge clk) begin
        line_word_t want;
        line_word_t got;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_SLAVE_ADDRESS) begin
                    reg_slave_address = cfg_ch.data[BYTE_W-1:0];
                end
                else if (cfg_ch.index == REG_HOLD_TICKS) begin
                    reg_hold_ticks = cfg_ch.data;
                end
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.scl_level, rsp_ch.sda_level, rsp_ch.busy_res,
                        rsp_ch.accepted, rsp_ch.transfer_done};
                if (pending_lines.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Cycle %0d: result word with nothing expected: %b",
                                 cycle_count, got);
                    end
                end
                else begin
                    want = pending_lines.pop_front();
                    words_checked++;
                    if (got.transfer_done === 1'b1) begin
                        transfers_seen++;
                    end
                    if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level
                        || got.busy_res !== want.busy_res || got.accepted !== want.accepted
                        || got.transfer_done !== want.transfer_done) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"Cycle %0d: mismatch, expected scl=%b sda=%b busy=%b ",
                                      "acc=%b done=%b, got scl=%b sda=%b busy=%b acc=%b done=%b"},
                                     cycle_count, want.scl_level, want.sda_level,
                                     want.busy_res, want.accepted, want.transfer_done,
                                     got.scl_level, got.sda_level, got.busy_res,
                                     got.accepted, got.transfer_done);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                pending_lines.push_back(predict_line_word(req_ch.operation,
                                                          req_ch.payload_byte));
            end
        end
    end

    // The result side stalls on its own schedule and honors long hold-off requests.
    initial begin
        bit          ready_phase;
        int unsigned run_left;
        ready_phase    = 1'b1;
        run_left       = 0;
        rsp_ch.ready   = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_request != 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0) begin
                rsp_ch.ready = 1'b0;
                holdoff_left--;
            end
            else begin
                case (rx_mode)
                    RX_ALWAYS: rsp_ch.ready = 1'b1;
                    RX_PATTERN:
                    begin
                        if (run_left == 0) begin
                            ready_phase = !ready_phase;
                            run_left    = ready_phase ? $urandom_range(1, 12)
                                                      : $urandom_range(1, 4);
                        end
                        run_left--;
                        rsp_ch.ready = ready_phase;
                    end
                    default: rsp_ch.ready = ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pay);
        int unsigned gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap          = $urandom_range(1, 6);
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        req_ch.valid        = 1'b1;
        req_ch.operation    = op;
        req_ch.payload_byte = pay;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending_lines.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        wait_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       send_word(OP_LOAD_CMD, BYTE_W'($urandom));
            1:       send_word(OP_LOAD_DATA, BYTE_W'($urandom));
            default: send_word(OP_RESERVED, BYTE_W'($urandom));
        endcase
    endtask

    task automatic run_transfer(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pay,
                                input int unsigned noise_pct);
        send_word(op, pay);
        traffic_words++;
        while (bus_active) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_noise();
            end
            send_word(OP_TICK, BYTE_W'($urandom));
            traffic_words++;
        end
    endtask

    task automatic test_idle_words();
        send_word(OP_TICK, 8'h00);
        send_word(OP_RESERVED, 8'hFF);
        send_word(OP_RESERVED, 8'h00);
        send_word(OP_TICK, 8'hFF);
        wait_drained();
    endtask

    task automatic test_default_transfers();
        run_transfer(OP_LOAD_CMD, 8'h00, 0);
        run_transfer(OP_LOAD_DATA, 8'hFF, 10);
        run_transfer(OP_LOAD_CMD, 8'h5A, 0);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_register(REG_SLAVE_ADDRESS, 16'h0000);
        write_register(REG_HOLD_TICKS, 16'h0000);
        run_transfer(OP_LOAD_DATA, 8'h55, 0);
        write_register(REG_SLAVE_ADDRESS, 16'h00FF);
        write_register(REG_HOLD_TICKS, 16'h0002);
        run_transfer(OP_LOAD_CMD, 8'hAA, 5);
        write_register(REG_SLAVE_ADDRESS, 16'h0096);
        write_register(REG_HOLD_TICKS, 16'd4);
        run_transfer(OP_LOAD_DATA, 8'h3C, 0);
        // The largest hold is only exercised while idle; a full transfer would be far too long.
        write_register(REG_HOLD_TICKS, 16'hFFFF);
        send_word(OP_TICK, 8'hC3);
        send_word(OP_RESERVED, 8'h3C);
        send_word(OP_TICK, 8'h00);
        write_register(REG_SLAVE_ADDRESS, 16'(SLAVE_ADDRESS_RESET));
        write_register(REG_HOLD_TICKS, HOLD_TICKS_RESET);
        wait_drained();
    endtask

    task automatic test_result_holdoff();
        rx_mode         = RX_ALWAYS;
        gaps_on         = 1'b0;
        holdoff_request = HOLDOFF_LONG;
        run_transfer(OP_LOAD_DATA, BYTE_W'($urandom), 5);
        run_transfer(OP_LOAD_CMD, BYTE_W'($urandom), 0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        int unsigned hold_eff;
        int unsigned partial;
        traffic_words = 0;
        while (traffic_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                hold_eff = 0;
            end
            else if (pick <= 6) begin
                hold_eff = 1;
            end
            else if (pick <= 8) begin
                hold_eff = 2;
            end
            else begin
                hold_eff = $urandom_range(3, 5);
            end
            write_register(REG_HOLD_TICKS, HOLD_W'(hold_eff));
            write_register(REG_SLAVE_ADDRESS, CFG_DAT_W'($urandom_range(0, 255)));
            if (hold_eff == 0) begin
                hold_eff = 1;
            end
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_noise();
                    end
                end
                else if (pick == 1) begin
                    send_word($urandom_range(0, 1) ? OP_LOAD_DATA : OP_LOAD_CMD,
                              BYTE_W'($urandom));
                    traffic_words++;
                    partial = $urandom_range(1, 91 * hold_eff - 1);
                    repeat (partial) begin
                        send_word(OP_TICK, BYTE_W'($urandom));
                        traffic_words++;
                    end
                end
                else begin
                    run_transfer($urandom_range(0, 1) ? OP_LOAD_DATA : OP_LOAD_CMD,
                                 BYTE_W'($urandom), 5);
                end
            end
            while (bus_active) begin
                send_word(OP_TICK, BYTE_W'($urandom));
                traffic_words++;
            end
        end
        wait_drained();
    endtask

    initial begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_TICK;
        req_ch.payload_byte = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_SLAVE_ADDRESS;
        cfg_ch.data         = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_words();
        rx_mode = RX_PATTERN;
        gaps_on = 1'b1;
        test_default_transfers();
        test_register_extremes();
        test_result_holdoff();
        test_random_traffic();

        wait_drained();
        $display("Checked %0d result words covering %0d complete transfers and %0d refused loads.",
                 words_checked, transfers_seen, loads_refused);
        $display({"Included idle and unused-operation words, register extremes, zero hold ",
                  "and a %0d-cycle result hold-off."}, HOLDOFF_LONG);
        if (mismatch_count == 0) begin
            $display("** i2c_display_write_sequencer_top: PASSED **");
        end
        else begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("** i2c_display_write_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/idws_pkg.sv
hw/rtl/idws_intf.sv
hw/rtl/idws_front.sv
hw/rtl/idws_queue.sv
hw/rtl/idws_back.sv
hw/rtl/i2c_display_write_sequencer_top.sv
dv/tb_top.sv
